>>> rtl/fls_pkg.sv
`default_nettype none

package fls_pkg;

  // pool size and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = 6;
  localparam int OWNER_W  = 32;

  // opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_ITER  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOT_USED = 2'd2;
  localparam logic [1:0] STAT_RANGE    = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [OWNER_W-1:0] owner_id;
    logic [SLOT_W-1:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot_out;
    logic [OWNER_W-1:0] owner_out;
    logic               valid_res;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/fls_ram.sv
`default_nettype none

module fls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/fls_ctrl.sv
`default_nettype none

module fls_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fls_pkg::in_item_t             in_data,
  output logic                               res_valid,
  output fls_pkg::out_item_t                 res_data,
  input  wire logic                          res_ready,
  output logic                               link_we,
  output logic      [fls_pkg::ADDR_W-1:0]    link_waddr,
  output logic      [fls_pkg::ADDR_W-1:0]    link_wdata,
  output logic      [fls_pkg::ADDR_W-1:0]    link_raddr,
  input  wire logic [fls_pkg::ADDR_W-1:0]    link_rdata,
  output logic                               owner_we,
  output logic      [fls_pkg::ADDR_W-1:0]    owner_waddr,
  output logic      [fls_pkg::OWNER_W-1:0]   owner_wdata,
  output logic      [fls_pkg::ADDR_W-1:0]    owner_raddr,
  input  wire logic [fls_pkg::OWNER_W-1:0]   owner_rdata
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ALLOC    = 6'b000010,
    S_FREE     = 6'b000100,
    S_SCAN_RD  = 6'b001000,
    S_SCAN_CHK = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  fls_pkg::in_item_t             cmd_r, cmd_nxt;
  fls_pkg::out_item_t            resp_r, resp_nxt;
  logic                          more_r, more_nxt;
  logic [fls_pkg::CAPACITY-1:0]  occ_r, occ_nxt;
  logic [fls_pkg::CAPACITY-1:0]  rem_r, rem_nxt;
  logic [fls_pkg::ADDR_W-1:0]    scan_i_r, scan_i_nxt;
  logic [fls_pkg::CNT_W-1:0]     free_head_r, free_head_nxt;
  logic [fls_pkg::CNT_W-1:0]     high_water_r, high_water_nxt;
  logic [fls_pkg::CNT_W-1:0]     used_r, used_nxt;

  fls_pkg::out_item_t            new_res;
  logic                          new_valid;
  logic                          new_more;
  logic [fls_pkg::ADDR_W-1:0]    in_idx_a;
  logic [fls_pkg::ADDR_W-1:0]    head_a;
  logic [fls_pkg::ADDR_W-1:0]    cmd_idx_a;
  logic                          in_range_bad;
  logic                          fresh;
  logic [fls_pkg::CNT_W-1:0]     head_next;
  logic [fls_pkg::CAPACITY-1:0]  rem_left;

  assign in_idx_a     = in_data.slot_index[fls_pkg::ADDR_W-1:0];
  assign head_a       = free_head_r[fls_pkg::ADDR_W-1:0];
  assign cmd_idx_a    = cmd_r.slot_index[fls_pkg::ADDR_W-1:0];
  assign in_range_bad = {1'b0, in_data.slot_index} >= (fls_pkg::SLOT_W+1)'(fls_pkg::CAPACITY);
  assign fresh        = free_head_r >= high_water_r;
  assign rem_left     = rem_r & ~(fls_pkg::CAPACITY'(1) << scan_i_r);

  assign in_stall    = (state_r != S_IDLE);
  assign link_raddr  = head_a;
  assign owner_raddr = (state_r == S_IDLE) ? in_idx_a : scan_i_r;
  assign link_waddr  = cmd_idx_a;
  assign link_wdata  = head_a;
  assign owner_waddr = head_a;
  assign owner_wdata = cmd_r.owner_id;

  assign res_valid = (state_r == S_RESP) || new_valid;
  assign res_data  = (state_r == S_RESP) ? resp_r : new_res;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    resp_nxt       = resp_r;
    more_nxt       = more_r;
    occ_nxt        = occ_r;
    rem_nxt        = rem_r;
    scan_i_nxt     = scan_i_r;
    free_head_nxt  = free_head_r;
    high_water_nxt = high_water_r;
    used_nxt       = used_r;
    new_res        = '0;
    new_valid      = 1'b0;
    new_more       = 1'b0;
    link_we        = 1'b0;
    owner_we       = 1'b0;
    head_next      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
          case (in_data.opcode)
            fls_pkg::OP_ALLOC: begin
              if (used_r >= fls_pkg::CNT_W'(fls_pkg::CAPACITY) ||
                  free_head_r >= fls_pkg::CNT_W'(fls_pkg::CAPACITY)) begin
                new_valid      = 1'b1;
                new_res.status = fls_pkg::STAT_FULL;
                new_res.last   = 1'b1;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            fls_pkg::OP_FREE: begin
              if (in_range_bad) begin
                new_valid      = 1'b1;
                new_res.status = fls_pkg::STAT_RANGE;
                new_res.last   = 1'b1;
              end else if (!occ_r[in_idx_a]) begin
                new_valid      = 1'b1;
                new_res.status = fls_pkg::STAT_NOT_USED;
                new_res.last   = 1'b1;
              end else begin
                state_nxt = S_FREE;
              end
            end
            fls_pkg::OP_ITER: begin
              if (occ_r == '0) begin
                // empty pool: single invalid result
                new_valid      = 1'b1;
                new_res.status = fls_pkg::STAT_OK;
                new_res.last   = 1'b1;
              end else begin
                rem_nxt    = occ_r;
                scan_i_nxt = '0;
                state_nxt  = S_SCAN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ALLOC: begin
        // link data for the head slot is ready this cycle
        if (fresh) begin
          head_next      = free_head_r + fls_pkg::CNT_W'(1);
          high_water_nxt = free_head_r + fls_pkg::CNT_W'(1);
        end else begin
          head_next = fls_pkg::CNT_W'(link_rdata);
        end
        if (used_r == fls_pkg::CNT_W'(fls_pkg::CAPACITY - 1)) begin
          head_next = fls_pkg::CNT_W'(fls_pkg::CAPACITY);
        end
        free_head_nxt     = head_next;
        owner_we          = 1'b1;
        occ_nxt[head_a]   = 1'b1;
        used_nxt          = used_r + fls_pkg::CNT_W'(1);
        new_valid         = 1'b1;
        new_res.status    = fls_pkg::STAT_OK;
        new_res.slot_out  = fls_pkg::SLOT_W'(free_head_r);
        new_res.owner_out = cmd_r.owner_id;
        new_res.valid_res = 1'b1;
        new_res.last      = 1'b1;
      end

      S_FREE: begin
        link_we            = 1'b1;
        free_head_nxt      = fls_pkg::CNT_W'(cmd_idx_a);
        occ_nxt[cmd_idx_a] = 1'b0;
        if (used_r != '0) begin
          used_nxt = used_r - fls_pkg::CNT_W'(1);
        end
        new_valid         = 1'b1;
        new_res.status    = fls_pkg::STAT_OK;
        new_res.slot_out  = cmd_r.slot_index;
        new_res.owner_out = owner_rdata;
        new_res.valid_res = 1'b1;
        new_res.last      = 1'b1;
      end

      S_SCAN_RD: begin
        // skip free slots, read owner of occupied ones
        if (rem_r[scan_i_r]) begin
          state_nxt = S_SCAN_CHK;
        end else begin
          scan_i_nxt = scan_i_r + fls_pkg::ADDR_W'(1);
        end
      end

      S_SCAN_CHK: begin
        rem_nxt           = rem_left;
        scan_i_nxt        = scan_i_r + fls_pkg::ADDR_W'(1);
        new_valid         = 1'b1;
        new_more          = (rem_left != '0);
        new_res.status    = fls_pkg::STAT_OK;
        new_res.slot_out  = fls_pkg::SLOT_W'(scan_i_r);
        new_res.owner_out = owner_rdata;
        new_res.valid_res = 1'b1;
        new_res.last      = (rem_left == '0);
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = more_r ? S_SCAN_RD : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hand the new result on, or park it until the output register has room
    if (new_valid) begin
      if (res_ready) begin
        state_nxt = new_more ? S_SCAN_RD : S_IDLE;
      end else begin
        resp_nxt  = new_res;
        more_nxt  = new_more;
        state_nxt = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      free_head_r  <= '0;
      high_water_r <= '0;
      used_r       <= '0;
      more_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      free_head_r  <= free_head_nxt;
      high_water_r <= high_water_nxt;
      used_r       <= used_nxt;
      more_r       <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    resp_r   <= resp_nxt;
    rem_r    <= rem_nxt;
    scan_i_r <= scan_i_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/free_list_slot_allocator_top.sv
// free list slot allocator
// input channel (in_valid / in_stall / in_data): one command per transfer,
//   allocate (owner id in), free (slot index in) or iterate; opcode 3 is
//   taken and dropped without a result
// result channel (out_valid / out_stall / out_data): one transfer per result,
//   last set on the final result of each command
// allocate and free are a link/owner memory read followed by the update
//   state (S_ALLOC or S_FREE), which hands the result on to the output
//   register; rejected commands (pool full, bad index, slot not in use) and
//   iterate on an empty pool hand their result on from the command cycle;
//   the input stays closed until an allocate or free is done, and iterate
//   walks the occupancy bits one slot a cycle while no result is parked,
//   with an extra S_SCAN_CHK state per occupied slot for its owner read
// in_stall is high while a command is in flight; the next command is taken
//   even while an earlier result waits in the output register
// a stalled result holds in the output register, and the sequencer parks the
//   next result until the register frees up
// reset (rst_n low, synchronous) empties the pool: no slot occupied, free
//   list restarts at slot 0, output register empty
`default_nettype none

module free_list_slot_allocator_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fls_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fls_pkg::out_item_t      out_data
);

  logic                            res_valid;
  fls_pkg::out_item_t              res_data;
  logic                            res_ready;

  logic                            link_we;
  logic [fls_pkg::ADDR_W-1:0]      link_waddr;
  logic [fls_pkg::ADDR_W-1:0]      link_wdata;
  logic [fls_pkg::ADDR_W-1:0]      link_raddr;
  logic [fls_pkg::ADDR_W-1:0]      link_rdata;
  logic                            owner_we;
  logic [fls_pkg::ADDR_W-1:0]      owner_waddr;
  logic [fls_pkg::OWNER_W-1:0]     owner_wdata;
  logic [fls_pkg::ADDR_W-1:0]      owner_raddr;
  logic [fls_pkg::OWNER_W-1:0]     owner_rdata;

  logic                            out_valid_r;
  fls_pkg::out_item_t              out_data_r;

  // sequencer and pool bookkeeping
  fls_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_data    (res_data),
    .res_ready   (res_ready),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .link_raddr  (link_raddr),
    .link_rdata  (link_rdata),
    .owner_we    (owner_we),
    .owner_waddr (owner_waddr),
    .owner_wdata (owner_wdata),
    .owner_raddr (owner_raddr),
    .owner_rdata (owner_rdata)
  );

  // free list links, one per slot
  fls_ram #(
    .WIDTH (fls_pkg::ADDR_W),
    .DEPTH (fls_pkg::CAPACITY),
    .AW    (fls_pkg::ADDR_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  // owner id of each slot
  fls_ram #(
    .WIDTH (fls_pkg::OWNER_W),
    .DEPTH (fls_pkg::CAPACITY),
    .AW    (fls_pkg::ADDR_W)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (owner_we),
    .wr_addr (owner_waddr),
    .wr_data (owner_wdata),
    .rd_addr (owner_raddr),
    .rd_data (owner_rdata)
  );

  // output register: takes a result when empty or when its content leaves
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/fls_checker.sv
`default_nettype none

module fls_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire fls_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fls_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // an unused opcode leaves the input open
  a_none_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == fls_pkg::OP_NONE) |=> !in_stall)
    else $error("unused opcode closed the input");

  // results without a slot always end the run
  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.last)
    else $error("invalid result not marked last");

  // error results carry no slot and no owner
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != fls_pkg::STAT_OK) |->
      !out_data.valid_res && (out_data.slot_out == '0) && (out_data.owner_out == '0))
    else $error("error result carries data");

endmodule

bind free_list_slot_allocator_top fls_checker u_fls_checker (.*);

`default_nettype wire
